### rtl/u8dec_pkg.sv
package u8dec_pkg;

  localparam logic [7:0] ASCII_LIMIT    = 8'h80;
  localparam logic [7:0] LEAD2_MAX      = 8'hDF;
  localparam logic [7:0] LEAD3_MAX      = 8'hEF;
  localparam logic [7:0] LEAD2_MASK     = 8'h1F;
  localparam logic [7:0] LEAD3_MASK     = 8'h0F;
  localparam logic [7:0] CONT_MASK      = 8'h3F;
  localparam logic [7:0] CONT_BASE      = 8'hC0;

  localparam int unsigned CONT_BITS     = 6;
  localparam int unsigned PARTIAL_W     = 12;
  localparam int unsigned UNIT_W        = 16;

  typedef logic [1:0]           pending_t;
  typedef logic [PARTIAL_W-1:0] partial_t;
  typedef logic [UNIT_W-1:0]    unit_t;

  localparam pending_t PEND_NONE = 2'd0;
  localparam pending_t PEND_ONE  = 2'd1;
  localparam pending_t PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    unit_t code_unit;
    logic  decode_error;
    logic  last_result;
  } result_t;

  typedef struct packed {
    pending_t bytes_pending;
    logic     skip_until_end;
  } core_status_t;

endpackage

### rtl/u8dec_in_if.sv
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

### rtl/u8dec_out_if.sv
interface u8dec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        decode_error;
  logic        last_result;

  modport source (output valid, output code_unit, output decode_error, output last_result,
                  input ready);
  modport sink (input valid, input code_unit, input decode_error, input last_result,
                output ready);
endinterface

### rtl/u8dec_in_stage.sv
module u8dec_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u8dec_pkg::in_item_t item_in,
  input  logic               consume,
  output logic               valid,
  output u8dec_pkg::in_item_t item_out
);

  logic                valid_r;
  logic                valid_nxt;
  u8dec_pkg::in_item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (consume) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule

### rtl/u8dec_core.sv
module u8dec_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  u8dec_pkg::in_item_t     item,
  output logic                    res_valid,
  output u8dec_pkg::result_t      res,
  output u8dec_pkg::core_status_t status
);

  u8dec_pkg::pending_t pending_r, pending_nxt;
  u8dec_pkg::partial_t partial_r, partial_nxt;
  logic                skip_r, skip_nxt;

  logic [7:0]          b;
  logic                eos;
  logic [17:0]         merged;
  u8dec_pkg::pending_t pend_dec;

  assign b        = item.data_byte;
  assign eos      = item.end_of_string;
  assign merged   = {partial_r, b[u8dec_pkg::CONT_BITS-1:0]};
  assign pend_dec = pending_r - u8dec_pkg::PEND_ONE;

  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    skip_nxt    = skip_r;
    res_valid   = 1'b0;
    res         = '0;

    if (skip_r) begin
      // Bytes after an error are dropped; end of string clears below.
    end else if (pending_r != u8dec_pkg::PEND_NONE) begin
      if (pend_dec == u8dec_pkg::PEND_NONE) begin
        partial_nxt      = '0;
        pending_nxt      = u8dec_pkg::PEND_NONE;
        res_valid        = 1'b1;
        res.code_unit    = merged[u8dec_pkg::UNIT_W-1:0];
        res.last_result  = eos;
      end else if (eos) begin
        res_valid        = 1'b1;
        res.decode_error = 1'b1;
        res.last_result  = 1'b1;
      end else begin
        pending_nxt = pend_dec;
        partial_nxt = merged[u8dec_pkg::PARTIAL_W-1:0];
      end
    end else begin
      priority if (b < u8dec_pkg::ASCII_LIMIT) begin
        res_valid       = 1'b1;
        res.code_unit   = {8'h00, b};
        res.last_result = eos;
      end else if (b >= u8dec_pkg::CONT_BASE && b <= u8dec_pkg::LEAD2_MAX) begin
        // A lead byte that ends the string is a truncated sequence.
        if (eos) begin
          res_valid        = 1'b1;
          res.decode_error = 1'b1;
          res.last_result  = 1'b1;
        end
        pending_nxt = u8dec_pkg::PEND_ONE;
        partial_nxt = {4'h0, b & u8dec_pkg::LEAD2_MASK};
      end else if (b > u8dec_pkg::LEAD2_MAX && b <= u8dec_pkg::LEAD3_MAX) begin
        if (eos) begin
          res_valid        = 1'b1;
          res.decode_error = 1'b1;
          res.last_result  = 1'b1;
        end
        pending_nxt = u8dec_pkg::PEND_TWO;
        partial_nxt = {4'h0, b & u8dec_pkg::LEAD3_MASK};
      end else begin
        // Stray continuation byte or a lead byte of four or more bytes.
        res_valid        = 1'b1;
        res.decode_error = 1'b1;
        res.last_result  = eos;
        skip_nxt         = 1'b1;
      end
    end

    // The last byte of a string always returns to the idle state.
    if (eos) begin
      pending_nxt = u8dec_pkg::PEND_NONE;
      partial_nxt = '0;
      skip_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= u8dec_pkg::PEND_NONE;
      partial_r <= '0;
      skip_r    <= 1'b0;
    end else if (step) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      skip_r    <= skip_nxt;
    end
  end

  assign status.bytes_pending  = pending_r;
  assign status.skip_until_end = skip_r;

endmodule

### rtl/u8dec_out_stage.sv
module u8dec_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u8dec_pkg::result_t res_in,
  input  logic               taken,
  output logic               free,
  output logic               valid,
  output u8dec_pkg::result_t res_out
);

  logic               valid_r;
  logic               valid_nxt;
  u8dec_pkg::result_t res_r;

  assign free = !valid_r || taken;

  always_comb begin
    valid_nxt = valid_r;
    if (taken) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

### rtl/utf8_to_ucs2_decoder_unit.sv
// UTF-8 to UCS-2 decoder. One byte enters per cycle on in_chan, flagged with
// end_of_string on the last byte of a string; each finished one-, two- or
// three-byte sequence leaves on out_chan as one 16-bit code unit. A byte
// passes through an input register, one level of decode logic and a result
// register. Its result is offered on out_chan once the decode step has
// moved it from the input register into the result register. A byte
// that only extends an open sequence yields nothing. Sustained rate is
// one byte per cycle as long as out_chan is ready; the result register is
// the only point of backpressure. A stray continuation byte, a lead byte of
// 0xF0 or above, or a string that ends mid-sequence gives one result with
// decode_error set and code_unit zero, and after the first two cases the
// rest of the string is dropped. Continuation bytes are not checked.
module utf8_to_ucs2_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_in_if.sink    in_chan,
  u8dec_out_if.source out_chan
);

  u8dec_pkg::in_item_t     in_item;
  u8dec_pkg::in_item_t     stage_item;
  logic                    stage_valid;
  logic                    step;
  logic                    res_valid;
  u8dec_pkg::result_t      res;
  u8dec_pkg::result_t      out_res;
  logic                    out_free;
  logic                    out_valid;
  u8dec_pkg::core_status_t status;
  logic                    in_accept;

  assign in_item.data_byte     = in_chan.data_byte;
  assign in_item.end_of_string = in_chan.end_of_string;

  // The decode step waits only when it would produce a result with nowhere to go.
  assign step          = stage_valid && (!res_valid || out_free);
  assign in_chan.ready = !stage_valid || step;
  assign in_accept     = in_chan.valid && in_chan.ready;

  u8dec_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_accept),
    .item_in  (in_item),
    .consume  (step),
    .valid    (stage_valid),
    .item_out (stage_item)
  );

  u8dec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (stage_item),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  u8dec_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step && res_valid),
    .res_in  (res),
    .taken   (out_valid && out_chan.ready),
    .free    (out_free),
    .valid   (out_valid),
    .res_out (out_res)
  );

  assign out_chan.valid        = out_valid;
  assign out_chan.code_unit    = out_res.code_unit;
  assign out_chan.decode_error = out_res.decode_error;
  assign out_chan.last_result  = out_res.last_result;

  a_error_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.decode_error |-> out_res.code_unit == '0)
    else $error("error result carries a nonzero code unit");

  a_eos_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    step && stage_item.end_of_string |=>
      status.bytes_pending == u8dec_pkg::PEND_NONE && !status.skip_until_end)
    else $error("decoder state not cleared after end of string");

  a_skip_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    status.skip_until_end |-> status.bytes_pending == u8dec_pkg::PEND_NONE)
    else $error("sequence open while dropping bytes");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid && !step |-> res_valid && !out_free)
    else $error("decode step stalled without output backpressure");

endmodule

### tb/u8dec_stream_checker.sv
module u8dec_stream_checker (
  input  logic clk,
  input  logic rst_n,
  u8dec_in_if  in_mon,
  u8dec_out_if out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   units_checked,
  output int   errors_flagged
);

  // Decoder state as the byte stream has left it so far.
  u8dec_pkg::pending_t bytes_left;
  u8dec_pkg::partial_t gathered_bits;
  logic                dropping;

  u8dec_pkg::result_t  unit_q[$];
  int                  fail_cnt;
  int                  unit_cnt;
  int                  err_cnt;

  function automatic void clear_string();
    bytes_left    = u8dec_pkg::PEND_NONE;
    gathered_bits = '0;
    dropping      = 1'b0;
  endfunction

  // Advances the decoder state by one byte. Returns 1 when the byte completes
  // a result, which is then left in unit.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output u8dec_pkg::result_t unit);
    u8dec_pkg::unit_t merged;
    unit = '0;
    if (dropping) begin
      if (eos) clear_string();
      return 1'b0;
    end
    if (bytes_left != u8dec_pkg::PEND_NONE) begin
      merged = u8dec_pkg::unit_t'((32'(gathered_bits) << u8dec_pkg::CONT_BITS) |
                                  32'(b & u8dec_pkg::CONT_MASK));
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == u8dec_pkg::PEND_NONE) begin
        gathered_bits = '0;
        if (eos) clear_string();
        unit.code_unit   = merged;
        unit.last_result = eos;
        return 1'b1;
      end
      if (eos) begin
        // The string ended in the middle of a three-byte sequence.
        clear_string();
        unit.decode_error = 1'b1;
        unit.last_result  = 1'b1;
        return 1'b1;
      end
      gathered_bits = u8dec_pkg::partial_t'(merged);
      return 1'b0;
    end
    if (b < u8dec_pkg::ASCII_LIMIT) begin
      if (eos) clear_string();
      unit.code_unit   = u8dec_pkg::unit_t'(b);
      unit.last_result = eos;
      return 1'b1;
    end
    if (b >= u8dec_pkg::CONT_BASE && b <= u8dec_pkg::LEAD3_MAX) begin
      if (eos) begin
        clear_string();
        unit.decode_error = 1'b1;
        unit.last_result  = 1'b1;
        return 1'b1;
      end
      if (b <= u8dec_pkg::LEAD2_MAX) begin
        gathered_bits = u8dec_pkg::partial_t'(b & u8dec_pkg::LEAD2_MASK);
        bytes_left    = u8dec_pkg::PEND_ONE;
      end else begin
        gathered_bits = u8dec_pkg::partial_t'(b & u8dec_pkg::LEAD3_MASK);
        bytes_left    = u8dec_pkg::PEND_TWO;
      end
      return 1'b0;
    end
    // Stray continuation byte or a lead byte of four bytes or more.
    if (eos) clear_string();
    else dropping = 1'b1;
    unit.decode_error = 1'b1;
    unit.last_result  = eos;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    u8dec_pkg::result_t want;
    u8dec_pkg::result_t got;
    if (!rst_n) begin
      clear_string();
      unit_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (decode_byte(in_mon.data_byte, in_mon.end_of_string, want))
          unit_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.code_unit    = out_mon.code_unit;
        got.decode_error = out_mon.decode_error;
        got.last_result  = out_mon.last_result;
        unit_cnt++;
        if (got.decode_error === 1'b1) err_cnt++;
        if (unit_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected transaction: code_unit %h decode_error %b last_result %b",
                   $time, got.code_unit, got.decode_error, got.last_result);
        end else begin
          want = unit_q.pop_front();
          if (got.code_unit !== want.code_unit) begin
            fail_cnt++;
            $display("%0t: code_unit expected %h, got %h",
                     $time, want.code_unit, got.code_unit);
          end
          if (got.decode_error !== want.decode_error) begin
            fail_cnt++;
            $display("%0t: decode_error expected %b, got %b",
                     $time, want.decode_error, got.decode_error);
          end
          if (got.last_result !== want.last_result) begin
            fail_cnt++;
            $display("%0t: last_result expected %b, got %b",
                     $time, want.last_result, got.last_result);
          end
        end
      end
    end
    mismatches     <= fail_cnt;
    outstanding    <= unit_q.size();
    units_checked  <= unit_cnt;
    errors_flagged <= err_cnt;
  end

  initial begin
    fail_cnt       = 0;
    unit_cnt       = 0;
    err_cnt        = 0;
    mismatches     = 0;
    outstanding    = 0;
    units_checked  = 0;
    errors_flagged = 0;
    clear_string();
  end

endmodule

### tb/tb_utf8_to_ucs2_decoder_unit.sv
module tb_utf8_to_ucs2_decoder_unit;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 275;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 64;
  localparam int SETTLE_TIME  = 12;

  logic clk;
  logic rst_n;

  u8dec_in_if  in_chan ();
  u8dec_out_if out_chan ();

  int mismatches;
  int outstanding;
  int units_checked;
  int errors_flagged;

  int idle_pct;
  int stall_pct;
  int bytes_sent;
  int strings_sent;
  int cycle_cnt;

  logic [7:0] str_q[$];

  utf8_to_ucs2_decoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  u8dec_stream_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .units_checked  (units_checked),
    .errors_flagged (errors_flagged)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_cnt, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off early in the run so
  // that the decoder fills up and pushes back on its input.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Returns at the edge where the byte is taken. The next call drives valid
  // once in that same step, so valid stays high across back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.end_of_string <= eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++)
      send_byte(str_q[i], i == str_q.size() - 1);
    strings_sent++;
    str_q.delete();
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] cont_byte();
    // Continuation bytes are not checked by the decoder, so some are junk.
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic void push_char();
    case ($urandom_range(2))
      0: str_q.push_back(8'($urandom_range(127)));
      1: begin
        str_q.push_back(8'hC0 | 8'($urandom_range(31)));
        str_q.push_back(cont_byte());
      end
      default: begin
        str_q.push_back(8'hE0 | 8'($urandom_range(15)));
        str_q.push_back(cont_byte());
        str_q.push_back(cont_byte());
      end
    endcase
  endfunction

  task automatic send_random_string();
    int kind;
    int n;
    kind = $urandom_range(99);
    n    = $urandom_range(1, 6);
    if (kind < 90) begin
      for (int i = 0; i < n; i++) push_char();
    end
    if (kind >= 70 && kind < 80) begin
      // A bad byte somewhere in the string; the rest of it is dropped.
      if ($urandom_range(1)) str_q.push_back(8'h80 | 8'($urandom_range(63)));
      else str_q.push_back(8'hF0 | 8'($urandom_range(15)));
      repeat ($urandom_range(3)) str_q.push_back(8'($urandom_range(255)));
    end else if (kind >= 80 && kind < 90) begin
      // The string stops inside a sequence.
      if ($urandom_range(2) == 0) begin
        str_q.push_back(8'hC0 | 8'($urandom_range(31)));
      end else begin
        str_q.push_back(8'hE0 | 8'($urandom_range(15)));
        if ($urandom_range(1)) str_q.push_back(cont_byte());
      end
    end else if (kind >= 90) begin
      for (int i = 0; i < n; i++) str_q.push_back(8'($urandom_range(255)));
    end
    send_string();
  endtask

  task automatic load(input logic [7:0] b);
    str_q.push_back(b);
  endtask

  initial begin
    int base;
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 76, 0, 13};
    phase_stall = '{0, 0, 76, 13};
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = 8'h00;
    in_chan.end_of_string = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    bytes_sent   = 0;
    strings_sent = 0;
    cycle_cnt    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: range edges of every byte class and each error path.
    load(8'h00); load(8'h7F); send_string();
    load(8'hC0); load(8'h80); load(8'hDF); load(8'hBF); send_string();
    load(8'hE0); load(8'h80); load(8'h80);
    load(8'hEF); load(8'hBF); load(8'hBF); send_string();
    load(8'h80); load(8'h41); load(8'hFF); send_string();
    load(8'hBF); send_string();
    load(8'hF0); send_string();
    load(8'hFF); load(8'h00); send_string();
    load(8'hC2); send_string();
    load(8'hE2); send_string();
    load(8'hE2); load(8'h80); send_string();
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      base      = bytes_sent;
      while (bytes_sent < base + PHASE_BYTES) send_random_string();
      // Hold the input back until every pending result has come out.
      drain();
    end

    stall_pct = 0;
    repeat (SETTLE_TIME) @(posedge clk);
    $display("sent %0d bytes in %0d strings under four idle and stall mixes",
             bytes_sent, strings_sent);
    $display("checked %0d results, %0d of them decode errors", units_checked, errors_flagged);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
